// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl module pal_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define PAL_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define PAL_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define PAL_ASSERT(label, clk, rst_n, prop)
`define PAL_NEVER(label, clk, rst_n, cond)
`endif

`endif

// ===== rtl/pal_pkg.sv =====
// types and constants of the positional array list
`timescale 1ns / 1ps
`default_nettype none

package pal_pkg;

  localparam int DEPTH  = 1024;
  localparam int DATA_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = IDX_W + 1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_REJECT    = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_FILL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] removed_value;
    logic [IDX_W-1:0]  found_index;
    logic [CNT_W-1:0]  entry_count;
    logic              is_full_flag;
    logic              is_empty_flag;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/pal_if.sv =====
// valid/ready channel interfaces for operations and results
`timescale 1ns / 1ps
`default_nettype none

interface pal_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        op;
  logic [pal_pkg::CNT_W-1:0]         position;
  logic signed [pal_pkg::DATA_W-1:0] value;

  modport source(output valid, op, position, value, input ready);
  modport sink(input valid, op, position, value, output ready);
endinterface

interface pal_out_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        status;
  logic signed [pal_pkg::DATA_W-1:0] removed_value;
  logic [pal_pkg::IDX_W-1:0]         found_index;
  logic [pal_pkg::CNT_W-1:0]         entry_count;
  logic                              is_full_flag;
  logic                              is_empty_flag;

  modport source(output valid, status, removed_value, found_index, entry_count,
                 is_full_flag, is_empty_flag, input ready);
  modport sink(input valid, status, removed_value, found_index, entry_count,
               is_full_flag, is_empty_flag, output ready);
endinterface

`default_nettype wire

// ===== rtl/pal_ram.sv =====
// simple dual port ram, one write and one registered read per cycle
`timescale 1ns / 1ps
`default_nettype none

module pal_ram #(
  parameter int AW = 10,
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [(1 << AW)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/pal_ctrl.sv =====
// operation sequencer: walks the entry memory for insert, delete and find
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pal_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  pal_in_if.sink                             in_ch,
  output pal_pkg::res_t                      res,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output pal_pkg::mem_req_t                  mem,
  input  wire logic [pal_pkg::DATA_W-1:0]    mem_rdata
);

  pal_pkg::state_t                  state_r, state_nxt;
  logic [pal_pkg::CNT_W-1:0]        count_r, count_nxt;
  pal_pkg::op_t                     op_r, op_nxt;
  logic [pal_pkg::CNT_W-1:0]        pos_r, pos_nxt;
  logic [pal_pkg::DATA_W-1:0]       word_r, word_nxt;
  logic [pal_pkg::IDX_W-1:0]        ptr_r, ptr_nxt;
  logic [pal_pkg::IDX_W-1:0]        end_r, end_nxt;
  logic                             prev_vld_r, prev_vld_nxt;
  logic [pal_pkg::IDX_W-1:0]        prev_addr_r, prev_addr_nxt;
  pal_pkg::status_t                 status_r, status_nxt;
  logic [pal_pkg::DATA_W-1:0]       removed_r, removed_nxt;
  logic [pal_pkg::IDX_W-1:0]        found_r, found_nxt;

  logic                             in_fire;
  pal_pkg::op_t                     in_op;
  logic                             list_full;
  logic                             ins_bad;
  logic                             del_bad;
  logic                             hit;

  assign in_ch.ready = (state_r == pal_pkg::S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_op       = pal_pkg::op_t'(in_ch.op);
  assign list_full   = (count_r == pal_pkg::CNT_W'(pal_pkg::DEPTH));
  assign ins_bad     = list_full || (in_ch.position > count_r);
  assign del_bad     = (in_ch.position >= count_r);
  // read data of the previous cycle's address compares against the key
  assign hit = prev_vld_r && (op_r == pal_pkg::OP_FIND) && (mem_rdata == word_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pal_pkg::S_IDLE: begin
        if (in_fire) begin
          case (in_op)
            pal_pkg::OP_INSERT: begin
              if (ins_bad) begin
                state_nxt = pal_pkg::S_DONE;
              end else if (in_ch.position == count_r) begin
                state_nxt = pal_pkg::S_FILL;
              end else begin
                state_nxt = pal_pkg::S_WALK;
              end
            end
            pal_pkg::OP_DELETE: begin
              state_nxt = del_bad ? pal_pkg::S_DONE : pal_pkg::S_WALK;
            end
            pal_pkg::OP_FIND: begin
              state_nxt = (count_r == '0) ? pal_pkg::S_DONE : pal_pkg::S_WALK;
            end
            pal_pkg::OP_CLEAR: begin
              state_nxt = pal_pkg::S_DONE;
            end
            default: begin
              state_nxt = pal_pkg::S_DONE;
            end
          endcase
        end
      end
      pal_pkg::S_WALK: begin
        if (hit) begin
          state_nxt = pal_pkg::S_DONE;
        end else if (ptr_r == end_r) begin
          state_nxt = pal_pkg::S_DRAIN;
        end
      end
      pal_pkg::S_DRAIN: begin
        state_nxt = (op_r == pal_pkg::OP_INSERT) ? pal_pkg::S_FILL : pal_pkg::S_DONE;
      end
      pal_pkg::S_FILL: begin
        state_nxt = pal_pkg::S_DONE;
      end
      pal_pkg::S_DONE: begin
        if (res_ready) begin
          state_nxt = pal_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pal_pkg::S_IDLE;
      end
    endcase
  end

  // datapath and memory controls
  always_comb begin
    count_nxt     = count_r;
    op_nxt        = op_r;
    pos_nxt       = pos_r;
    word_nxt      = word_r;
    ptr_nxt       = ptr_r;
    end_nxt       = end_r;
    status_nxt    = status_r;
    removed_nxt   = removed_r;
    found_nxt     = found_r;
    prev_vld_nxt  = (state_r == pal_pkg::S_WALK) && !hit;
    prev_addr_nxt = ptr_r;
    mem.we        = 1'b0;
    mem.waddr     = prev_addr_r;
    mem.wdata     = mem_rdata;
    mem.raddr     = ptr_r;

    case (state_r)
      pal_pkg::S_IDLE: begin
        if (in_fire) begin
          op_nxt      = in_op;
          pos_nxt     = in_ch.position;
          word_nxt    = pal_pkg::DATA_W'(unsigned'(in_ch.value));
          removed_nxt = '0;
          found_nxt   = '0;
          case (in_op)
            pal_pkg::OP_INSERT: begin
              status_nxt = ins_bad ? pal_pkg::STAT_REJECT : pal_pkg::STAT_OK;
              ptr_nxt    = pal_pkg::IDX_W'(count_r - 1'b1);
              end_nxt    = in_ch.position[pal_pkg::IDX_W-1:0];
            end
            pal_pkg::OP_DELETE: begin
              status_nxt = del_bad ? pal_pkg::STAT_REJECT : pal_pkg::STAT_OK;
              ptr_nxt    = in_ch.position[pal_pkg::IDX_W-1:0];
              end_nxt    = pal_pkg::IDX_W'(count_r - 1'b1);
            end
            pal_pkg::OP_FIND: begin
              status_nxt = pal_pkg::STAT_NOT_FOUND;
              ptr_nxt    = '0;
              end_nxt    = pal_pkg::IDX_W'(count_r - 1'b1);
            end
            pal_pkg::OP_CLEAR: begin
              status_nxt = pal_pkg::STAT_OK;
              count_nxt  = '0;
            end
            default: begin
              status_nxt = pal_pkg::STAT_OK;
              count_nxt  = '0;
            end
          endcase
        end
      end
      pal_pkg::S_WALK: begin
        // insert walks down from the tail, the others walk up
        ptr_nxt = (op_r == pal_pkg::OP_INSERT) ? ptr_r - 1'b1 : ptr_r + 1'b1;
      end
      pal_pkg::S_DRAIN: begin
        if (op_r == pal_pkg::OP_DELETE) begin
          count_nxt = count_r - 1'b1;
        end
      end
      pal_pkg::S_FILL: begin
        mem.we    = 1'b1;
        mem.waddr = pos_r[pal_pkg::IDX_W-1:0];
        mem.wdata = word_r;
        count_nxt = count_r + 1'b1;
      end
      default: begin
      end
    endcase

    // handle the word whose read was issued in the previous cycle
    if (prev_vld_r) begin
      case (op_r)
        pal_pkg::OP_INSERT: begin
          mem.we    = 1'b1;
          mem.waddr = prev_addr_r + 1'b1;
        end
        pal_pkg::OP_DELETE: begin
          if (prev_addr_r == pos_r[pal_pkg::IDX_W-1:0]) begin
            removed_nxt = mem_rdata;
          end else begin
            mem.we    = 1'b1;
            mem.waddr = prev_addr_r - 1'b1;
          end
        end
        pal_pkg::OP_FIND: begin
          if (hit) begin
            status_nxt = pal_pkg::STAT_OK;
            found_nxt  = prev_addr_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= pal_pkg::S_IDLE;
      count_r    <= '0;
      prev_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      prev_vld_r <= prev_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    pos_r       <= pos_nxt;
    word_r      <= word_nxt;
    ptr_r       <= ptr_nxt;
    end_r       <= end_nxt;
    prev_addr_r <= prev_addr_nxt;
    status_r    <= status_nxt;
    removed_r   <= removed_nxt;
    found_r     <= found_nxt;
  end

  assign res_valid         = (state_r == pal_pkg::S_DONE);
  assign res.status        = status_r;
  assign res.removed_value = removed_r;
  assign res.found_index   = found_r;
  assign res.entry_count   = count_r;
  assign res.is_full_flag  = list_full;
  assign res.is_empty_flag = (count_r == '0);

  `PAL_NEVER(a_count_range, clk, rst_n, count_r > pal_pkg::CNT_W'(pal_pkg::DEPTH))
  `PAL_NEVER(a_rw_collide, clk, rst_n,
             mem.we && (state_r == pal_pkg::S_WALK) && (mem.waddr == mem.raddr))
  `PAL_ASSERT(a_write_phase, clk, rst_n,
              mem.we |-> (state_r == pal_pkg::S_WALK || state_r == pal_pkg::S_DRAIN ||
                          state_r == pal_pkg::S_FILL))
  `PAL_ASSERT(a_walk_end, clk, rst_n,
              (state_r == pal_pkg::S_WALK && ptr_r == end_r && !hit) |=>
              (state_r == pal_pkg::S_DRAIN))

endmodule

`default_nettype wire

// ===== rtl/positional_array_list_unit.sv =====
// Positional array list: an ordered list of up to 1024 signed 32-bit words.
//
// in_ch carries one operation per beat (op, position, value): insert, delete,
// find or clear. out_ch returns one result beat per operation with status,
// removed word, found index, entry count and full/empty flags.
// Operations are handled one at a time. An insert at position p walks from
// the tail down to p, moving each entry up by one, then writes the new word
// (an append skips the walk); a delete walks from p to the tail, moving each
// entry down by one; a find walks up from index 0 and stops at the first
// match; rejected operations and clear skip the walk. The walk moves one
// entry per cycle through the single-port-read entry memory.
// A finished result sits in an output register, so in_ch is ready again
// as soon as the result is handed over; a stalled out_ch holds that
// register and the next operation stops at its result until it drains.
// Reset (rst_n low, synchronous) empties the list and drops any pending
// result; the stored words are not cleared and only valid entries are read.
`timescale 1ns / 1ps
`default_nettype none

module positional_array_list_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  pal_in_if.sink    in_ch,
  pal_out_if.source out_ch
);

  pal_pkg::res_t                res;
  logic                         res_valid;
  logic                         res_ready;
  pal_pkg::mem_req_t            mem;
  logic [pal_pkg::DATA_W-1:0]   mem_rdata;
  logic                         out_vld_r;
  pal_pkg::res_t                out_res_r;

  pal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .mem       (mem),
    .mem_rdata (mem_rdata)
  );

  pal_ram #(
    .AW (pal_pkg::IDX_W),
    .DW (pal_pkg::DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .raddr (mem.raddr),
    .rdata (mem_rdata)
  );

  // output register frees the sequencer while the result waits
  assign res_ready = !out_vld_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_ready) begin
      out_vld_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.status        = out_res_r.status;
  assign out_ch.removed_value = signed'(out_res_r.removed_value);
  assign out_ch.found_index   = out_res_r.found_index;
  assign out_ch.entry_count   = out_res_r.entry_count;
  assign out_ch.is_full_flag  = out_res_r.is_full_flag;
  assign out_ch.is_empty_flag = out_res_r.is_empty_flag;

endmodule

`default_nettype wire

// ===== tb/pal_checker.sv =====
// checker for the positional array list: shadow list, expected results, beat compare
`timescale 1ns / 1ps

module pal_checker (
  input  logic clk,
  input  logic rst_n,
  pal_in_if    in_ch,
  pal_out_if   out_ch,
  output int   fail_count,
  output int   outstanding,
  output int   list_len
);
  import pal_pkg::*;

  logic [DATA_W-1:0] words [DEPTH];
  int                held;
  int                bad_beats;
  res_t              due_results[$];

  // applies one operation to the shadow list and returns the result it gives
  function automatic res_t edit_list(op_t op, logic [CNT_W-1:0] pos,
                                     logic [DATA_W-1:0] word);
    res_t r;
    int   i;
    r = '0;
    r.status = STAT_OK;
    case (op)
      OP_INSERT: begin
        if (held >= DEPTH || pos > held) begin
          r.status = STAT_REJECT;
        end else begin
          for (i = held; i > pos; i--) words[i] = words[i-1];
          words[pos] = word;
          held++;
        end
      end
      OP_DELETE: begin
        if (pos >= held) begin
          r.status = STAT_REJECT;
        end else begin
          r.removed_value = words[pos];
          for (i = pos; i + 1 < held; i++) words[i] = words[i+1];
          held--;
        end
      end
      OP_FIND: begin
        // only the valid entries are searched, lowest index wins
        r.status = STAT_NOT_FOUND;
        for (i = 0; i < held; i++) begin
          if (words[i] == word) begin
            r.status = STAT_OK;
            r.found_index = IDX_W'(i);
            break;
          end
        end
      end
      OP_CLEAR: begin
        held = 0;
      end
    endcase
    r.entry_count   = CNT_W'(held);
    r.is_full_flag  = (held == DEPTH);
    r.is_empty_flag = (held == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      held = 0;
      bad_beats = 0;
      due_results.delete();
    end else begin
      // a result beat always belongs to an earlier operation, so pop first
      if (out_ch.valid && out_ch.ready) begin
        if (due_results.size() == 0) begin
          bad_beats++;
          if (bad_beats <= 10) $display("result beat with nothing pending");
        end else begin
          want = due_results.pop_front();
          if (out_ch.status != want.status || out_ch.removed_value != want.removed_value ||
              out_ch.found_index != want.found_index ||
              out_ch.entry_count != want.entry_count ||
              out_ch.is_full_flag != want.is_full_flag ||
              out_ch.is_empty_flag != want.is_empty_flag) begin
            bad_beats++;
            if (bad_beats <= 10) begin
              $display("result mismatch: status %0d exp %0d, removed %0d exp %0d,",
                       out_ch.status, want.status, out_ch.removed_value,
                       $signed(want.removed_value));
              $display("  index %0d exp %0d, count %0d exp %0d, full %0b exp %0b, empty %0b exp %0b",
                       out_ch.found_index, want.found_index, out_ch.entry_count,
                       want.entry_count, out_ch.is_full_flag, want.is_full_flag,
                       out_ch.is_empty_flag, want.is_empty_flag);
            end
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        due_results.push_back(edit_list(op_t'(in_ch.op), in_ch.position, in_ch.value));
    end
    fail_count  <= bad_beats;
    outstanding <= due_results.size();
    list_len    <= held;
  end

endmodule

// ===== tb/positional_array_list_unit_tb.sv =====
// top of the positional array list testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module positional_array_list_unit_tb;
  import pal_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int LONG_HOLD   = 300;

  logic clk = 1'b0;
  logic rst_n;
  int   fails;
  int   pending;
  int   list_len;
  int   idle_cycles = 0;
  int   tx_items = 0;
  int   rx_beats = 0;
  bit   tx_calm = 1'b0;
  bit   rx_calm = 1'b0;
  logic [DATA_W-1:0] value_pool[$];

  pal_in_if  in_ch();
  pal_out_if out_ch();

  positional_array_list_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pal_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_count  (fails),
    .outstanding (pending),
    .list_len    (list_len)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // offers one operation beat; called and returns at a falling edge
  task automatic send_op(input op_t op, input int pos, input logic [DATA_W-1:0] word);
    int gap;
    if (tx_items % 32 == 0) tx_calm = ($urandom_range(0, 3) == 0);
    gap = tx_calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.op       <= op;
    in_ch.position <= CNT_W'(pos);
    in_ch.value    <= word;
    in_ch.valid    <= 1'b1;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    tx_items++;
    @(negedge clk);
  endtask

  // word for an insert: small values give duplicates so first-match matters
  function automatic logic [DATA_W-1:0] fresh_word();
    logic [DATA_W-1:0] w;
    if ($urandom_range(0, 3) == 0) w = DATA_W'($urandom_range(0, 7));
    else w = $urandom;
    value_pool.push_back(w);
    if (value_pool.size() > 48) void'(value_pool.pop_front());
    return w;
  endfunction

  // result side: random stalls, calm stretches, and long hold-offs that back up the input
  initial begin : result_drain
    int gap;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (rx_beats % 32 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      gap = rx_calm ? 0 : $urandom_range(0, 5);
      if (rx_beats == 60 || rx_beats == 1200) gap = LONG_HOLD;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      rx_beats++;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("positional_array_list_unit_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int                roll;
    int                pos;
    int                len_cap;
    logic [DATA_W-1:0] word;
    logic [DATA_W-1:0] last_word;

    in_ch.valid    = 1'b0;
    in_ch.op       = OP_INSERT;
    in_ch.position = '0;
    in_ch.value    = '0;
    rst_n          = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty list, extremes of the word, bad positions, dup values
    send_op(OP_DELETE, 0, 32'h0000_0001);
    send_op(OP_FIND,   0, 32'h0000_0000);
    send_op(OP_INSERT, 1, 32'h0000_0003);
    send_op(OP_INSERT, 0, 32'h7FFF_FFFF);
    send_op(OP_INSERT, 1, 32'h8000_0000);
    send_op(OP_INSERT, 0, 32'h0000_0000);
    send_op(OP_INSERT, 1, 32'hFFFF_FFFF);
    send_op(OP_INSERT, 2, 32'h0000_0000);
    send_op(OP_FIND,   0, 32'h0000_0000);
    send_op(OP_FIND,   0, 32'h8000_0000);
    send_op(OP_FIND,   0, 32'd12345);
    send_op(OP_INSERT, 2047, 32'h0000_0005);
    send_op(OP_INSERT, DEPTH, 32'h0000_0005);
    send_op(OP_DELETE, DEPTH, 32'h0000_0000);
    send_op(OP_DELETE, 5, 32'h0000_0000);
    send_op(OP_DELETE, 4, 32'h0000_0000);
    send_op(OP_DELETE, 0, 32'h0000_0000);
    send_op(OP_FIND,   0, 32'h0000_0000);
    send_op(OP_CLEAR,  2047, 32'hFFFF_FFFF);
    send_op(OP_FIND,   0, 32'h7FFF_FFFF);
    send_op(OP_DELETE, 0, 32'h0000_0000);
    send_op(OP_CLEAR,  0, 32'h0000_0000);
    send_op(OP_INSERT, 0, 32'h5555_5555);
    send_op(OP_INSERT, 1, 32'hAAAA_AAAA);

    // random: list length mostly kept short so walks stay cheap
    len_cap = 16;
    for (int n = 0; n < 500; n++) begin
      if (n % 50 == 0) len_cap = ($urandom_range(0, 4) == 0) ? 160 : $urandom_range(4, 40);
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        send_op(OP_CLEAR, $urandom_range(0, 2047), $urandom);
      end else if (roll < 9) begin
        send_op(op_t'($urandom_range(0, 3)), $urandom_range(0, 2047), $urandom);
      end else if (roll < 50 && list_len < len_cap) begin
        if ($urandom_range(0, 19) == 0) pos = list_len + 1 + $urandom_range(0, 3);
        else pos = $urandom_range(0, list_len);
        send_op(OP_INSERT, pos, fresh_word());
      end else if (roll < 72) begin
        if (list_len == 0 || $urandom_range(0, 19) == 0)
          pos = list_len + $urandom_range(0, 3);
        else
          pos = $urandom_range(0, list_len - 1);
        send_op(OP_DELETE, pos, $urandom);
      end else begin
        if (value_pool.size() > 0 && $urandom_range(0, 3) != 0)
          word = value_pool[$urandom_range(0, value_pool.size() - 1)];
        else
          word = $urandom;
        send_op(OP_FIND, $urandom_range(0, 2047), word);
      end
    end

    // fill to capacity with cheap appends, then the full-list corner cases
    send_op(OP_CLEAR, 0, '0);
    last_word = '0;
    while (list_len < DEPTH) begin
      last_word = $urandom;
      send_op(OP_INSERT, list_len, last_word);
    end
    send_op(OP_INSERT, DEPTH, $urandom);
    send_op(OP_INSERT, 0, $urandom);
    send_op(OP_FIND,   0, last_word);
    send_op(OP_FIND,   0, $urandom);
    send_op(OP_DELETE, 0, '0);
    send_op(OP_INSERT, 0, 32'h8000_0000);
    send_op(OP_DELETE, DEPTH - 1, '0);
    send_op(OP_INSERT, DEPTH - 1, 32'h7FFF_FFFF);
    send_op(OP_DELETE, DEPTH, '0);
    send_op(OP_CLEAR,  DEPTH, '1);
    send_op(OP_FIND,   0, last_word);

    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("positional_array_list_unit_tb: done, clean");
    end else begin
      $display("positional_array_list_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
